// ===== src/twb_pkg.sv =====
// shared types and constants for the two-wheel balance controller
`default_nettype none
package twb_pkg;

  // fixed-point layout
  localparam int ValW    = 16;        // Q11.4 angle and rate
  localparam int GainW   = 16;        // Q0.16 gains
  localparam int StepW   = 8;
  localparam int OlimW   = 11;
  localparam int TiltW   = 15;
  localparam int AccW    = 12;
  localparam int DutyW   = 11;
  localparam int FracW   = 20;        // product fraction bits
  localparam int SumW    = 36;        // exact sum of three products
  localparam int IncW    = 29;        // clamped increment, +/-255 << 20
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;
  localparam int InDataW = 4 * ValW;
  localparam int OutDataW = 24;       // two duties and two pins, byte aligned

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP           = 3'd0,
    REG_KI           = 3'd1,
    REG_KD           = 3'd2,
    REG_STEP_LIMIT   = 3'd3,
    REG_OUTPUT_LIMIT = 3'd4,
    REG_TILT_LIMIT   = 3'd5
  } cfg_reg_t;

  // reset values of the registers
  localparam logic [GainW-1:0] KpReset   = 16'd1966;
  localparam logic [GainW-1:0] KiReset   = 16'd39322;
  localparam logic [GainW-1:0] KdReset   = 16'd13107;
  localparam logic [StepW-1:0] StepReset = 8'd20;
  localparam logic [OlimW-1:0] OlimReset = 11'd1500;
  localparam logic [TiltW-1:0] TiltReset = 15'd800;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
    logic [StepW-1:0] step_limit;
    logic [OlimW-1:0] output_limit;
    logic [TiltW-1:0] tilt_limit;
  } gains_t;

  // what one wheel lane hands to the merge stage
  typedef struct packed {
    logic                   valid;
    logic                   armed;
    logic                   tilt_ok;
    logic signed [AccW-1:0] accum;
  } lane_out_t;

endpackage
`default_nettype wire

// ===== src/two_wheel_incremental_balance_pid_top.sv =====
// top level of the two-wheel incremental balance controller
`default_nettype none
// Two-wheel balance controller: one incremental PID lane per wheel, a merge
// stage that gates both drives on tilt and forms the duty/direction word, and
// a result queue. A new tick word can be taken every clock cycle; a result
// word is offered once its tick has passed lane stages one, two and three,
// the merge register and the queue write, and then waits in the queue.
// The input stays ready as long as fewer than FIFO_DEPTH ticks are taken but
// not yet delivered, so full rate needs FIFO_DEPTH of at least six with the
// output always ready. Each lane's accumulator update is combinational from
// its own register, which is what sets the one-per-cycle figure.
// Configuration writes are always ready and take effect in the next cycle;
// write them only while no tick is in flight.
module two_wheel_incremental_balance_pid_top #(
  parameter int FIFO_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // left_angle, right_angle, left_rate, right_rate
  input  wire logic [twb_pkg::InDataW-1:0]   s_tdata,
  // armed
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // left_duty, left_dir, right_duty, right_dir
  output logic [twb_pkg::OutDataW-1:0]       m_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [twb_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [twb_pkg::CfgDatW-1:0]   cfg_data
);
  import twb_pkg::*;

  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  gains_t          gains;
  lane_out_t       left_res, right_res;
  logic            accept, pop;
  logic [CntW-1:0] inflight;
  logic            word_valid;
  logic [OutDataW-1:0] word;

  assign accept = s_tvalid && s_tready;
  assign pop = m_tvalid && m_tready;
  assign s_tready = inflight != CntW'(FIFO_DEPTH);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp <= KpReset;
      gains.ki <= KiReset;
      gains.kd <= KdReset;
      gains.step_limit <= StepReset;
      gains.output_limit <= OlimReset;
      gains.tilt_limit <= TiltReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KP:           gains.kp <= cfg_data;
        REG_KI:           gains.ki <= cfg_data;
        REG_KD:           gains.kd <= cfg_data;
        REG_STEP_LIMIT:   gains.step_limit <= cfg_data[StepW-1:0];
        REG_OUTPUT_LIMIT: gains.output_limit <= cfg_data[OlimW-1:0];
        REG_TILT_LIMIT:   gains.tilt_limit <= cfg_data[TiltW-1:0];
        default: ;
      endcase
    end
  end

  // ticks taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CntW'(accept) - CntW'(pop);
    end
  end

  // wheel lanes
  twb_lane u_left (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .armed    (s_tuser),
    .angle    ($signed(s_tdata[ValW-1:0])),
    .rate     ($signed(s_tdata[3*ValW-1:2*ValW])),
    .gains    (gains),
    .result   (left_res)
  );

  twb_lane u_right (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .armed    (s_tuser),
    .angle    ($signed(s_tdata[2*ValW-1:ValW])),
    .rate     ($signed(s_tdata[4*ValW-1:3*ValW])),
    .gains    (gains),
    .result   (right_res)
  );

  // merge both wheels
  twb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .left       (left_res),
    .right      (right_res),
    .word_valid (word_valid),
    .word       (word)
  );

  // result queue
  twb_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (OutDataW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (word_valid),
    .push_data (word),
    .pop_valid (m_tvalid),
    .pop_ready (m_tready),
    .pop_data  (m_tdata)
  );

endmodule
`default_nettype wire

// ===== src/twb_lane.sv =====
// one wheel: products, clamped increment and accumulator update
`default_nettype none
module twb_lane (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic                             armed,
  input  wire logic signed [twb_pkg::ValW-1:0]  angle,
  input  wire logic signed [twb_pkg::ValW-1:0]  rate,
  input  wire twb_pkg::gains_t                  gains,
  output twb_pkg::lane_out_t                    result
);
  import twb_pkg::*;

  localparam int ProdW = 2 * ValW + 1;
  localparam int DiffW = ValW + 1;
  localparam int DProdW = 2 * DiffW;
  localparam int VW = AccW + FracW + 1;
  localparam int QW = VW - FracW;

  logic signed [ValW-1:0]   prev_rate;
  logic signed [DiffW-1:0]  diff;

  // stage 1 registers
  logic                     v1, armed1, tilt1;
  logic signed [ProdW-1:0]  prod_p, prod_i;
  logic signed [DProdW-1:0] prod_d;

  // stage 2 registers
  logic                     v2, armed2, tilt2;
  logic signed [IncW-1:0]   inc;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   lim;
  logic signed [IncW-1:0]   inc_next;

  // stage 3 registers
  logic                     v3, armed3, tilt3;
  logic signed [AccW-1:0]   accum;
  logic signed [VW-1:0]     vsum, vbias;
  logic signed [QW-1:0]     q, olim, q_sat;
  logic [ValW:0]            angle_mag;

  // rate change and angle magnitude
  always_comb begin
    diff = DiffW'(rate) - DiffW'(prev_rate);
    angle_mag = angle[ValW-1] ? (~{angle[ValW-1], angle} + 1'b1) : {1'b0, angle};
  end

  // stage 1: three products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      prev_rate <= '0;
    end else begin
      v1 <= in_valid;
      if (in_valid && armed) begin
        prev_rate <= rate;
      end
    end
    armed1 <= armed;
    tilt1 <= angle_mag < {2'b00, gains.tilt_limit};
    prod_p <= ProdW'($signed({1'b0, gains.kp}) * rate);
    prod_i <= ProdW'($signed({1'b0, gains.ki}) * angle);
    prod_d <= DProdW'($signed({1'b0, gains.kd}) * diff);
  end

  // sum and clamp to the step limit
  always_comb begin
    sum = SumW'(prod_p) + SumW'(prod_i) + SumW'(prod_d);
    lim = $signed(SumW'({gains.step_limit, {FracW{1'b0}}}));
    if (sum > lim) begin
      inc_next = IncW'(lim);
    end else if (sum < -lim) begin
      inc_next = IncW'(-lim);
    end else begin
      inc_next = IncW'(sum);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    armed2 <= armed1;
    tilt2 <= tilt1;
    inc <= inc_next;
  end

  // accumulator step, truncated toward zero, then saturated
  always_comb begin
    vsum = $signed({accum[AccW-1], accum, {FracW{1'b0}}}) - VW'(inc);
    vbias = vsum[VW-1] ? VW'({FracW{1'b1}}) : '0;
    vsum = vsum + vbias;
    q = vsum[VW-1:FracW];
    olim = $signed({{(QW-OlimW){1'b0}}, gains.output_limit});
    if (q > olim) begin
      q_sat = olim;
    end else if (q < -olim) begin
      q_sat = -olim;
    end else begin
      q_sat = q;
    end
  end

  // stage 3: accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      accum <= '0;
    end else begin
      v3 <= v2;
      if (v2) begin
        accum <= armed2 ? AccW'(q_sat) : '0;
      end
    end
    armed3 <= armed2;
    tilt3 <= tilt2;
  end

  assign result.valid   = v3;
  assign result.armed   = armed3;
  assign result.tilt_ok = tilt3;
  assign result.accum   = accum;

endmodule
`default_nettype wire

// ===== src/twb_merge.sv =====
// combines both lanes: tilt gate, direction pins and duty word
`default_nettype none
module twb_merge (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire twb_pkg::lane_out_t                left,
  input  wire twb_pkg::lane_out_t                right,
  output logic                                   word_valid,
  output logic [twb_pkg::OutDataW-1:0]           word
);
  import twb_pkg::*;

  logic             left_dir_pin, right_dir_pin;
  logic             drive;
  logic [AccW-1:0]  lmag, rmag;
  logic             ldir_next, rdir_next;
  logic [DutyW-1:0] lduty, rduty;

  // motors run only when armed and both angles are inside the limit
  always_comb begin
    drive = left.armed && right.armed && left.tilt_ok && right.tilt_ok;
    lmag = left.accum[AccW-1] ? AccW'(-left.accum) : AccW'(left.accum);
    rmag = right.accum[AccW-1] ? AccW'(-right.accum) : AccW'(right.accum);
    ldir_next = drive ? (left.accum > 0) : left_dir_pin;
    rdir_next = drive ? !(right.accum > 0) : right_dir_pin;
    lduty = drive ? lmag[DutyW-1:0] : '0;
    rduty = drive ? rmag[DutyW-1:0] : '0;
  end

  // held pins and registered result word
  always_ff @(posedge clk) begin
    if (rst) begin
      left_dir_pin <= 1'b0;
      right_dir_pin <= 1'b0;
      word_valid <= 1'b0;
    end else begin
      word_valid <= left.valid && right.valid;
      if (left.valid && right.valid) begin
        left_dir_pin <= ldir_next;
        right_dir_pin <= rdir_next;
      end
    end
    word <= {rdir_next, rduty, ldir_next, lduty};
  end

endmodule
`default_nettype wire

// ===== src/twb_fifo.sv =====
// result queue that decouples the pipeline from the output handshake
`default_nettype none
module twb_fifo #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  logic             pop;

  assign pop = pop_valid && pop_ready;
  assign pop_valid = count != '0;
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the two-wheel incremental balance controller
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import twb_pkg::*;

  // one result word, laid out as m_tdata from the top bit down
  typedef struct packed {
    logic             right_dir;
    logic [DutyW-1:0] right_duty;
    logic             left_dir;
    logic [DutyW-1:0] left_duty;
  } drive_t;

  // one line of the directed plan: a register write or a tick word
  typedef struct packed {
    logic                   is_write;
    logic [CfgIdxW-1:0]     idx;
    logic [CfgDatW-1:0]     data;
    logic signed [ValW-1:0] la;
    logic signed [ValW-1:0] ra;
    logic signed [ValW-1:0] lr;
    logic signed [ValW-1:0] rr;
    logic                   armed;
    logic                   pinned;
    drive_t                 want;
  } plan_row_t;

  localparam int NumPlanRows = 42;
  localparam int PhaseTicks = 160;
  localparam longint QOne = longint'(1) << FracW;
  // indexes past the register file, writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid, s_tready, s_tuser;
  logic [InDataW-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;

  two_wheel_incremental_balance_pid_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the register file and of the controller state
  gains_t live_gains = '{kp: KpReset, ki: KiReset, kd: KdReset, step_limit: StepReset,
                         output_limit: OlimReset, tilt_limit: TiltReset};
  longint acc_l = 0, acc_r = 0;
  longint prev_l = 0, prev_r = 0;
  logic dir_l = 1'b0, dir_r = 1'b0;

  drive_t drive_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic pin_on = 1'b0;
  drive_t pin_drive = '0;
  plan_row_t plan [NumPlanRows];

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // one wheel: clamped increment, truncate toward zero, saturate
  function automatic longint wheel_step(longint acc, longint angle, longint rate,
                                        longint prior);
    longint s, lim, v, q, olim;
    s = longint'(live_gains.kp) * rate + longint'(live_gains.ki) * angle
      + longint'(live_gains.kd) * (rate - prior);
    lim = longint'(live_gains.step_limit) * QOne;
    if (s > lim) s = lim;
    else if (s < -lim) s = -lim;
    v = acc * QOne - s;
    q = v / QOne;
    olim = longint'(live_gains.output_limit);
    if (q > olim) q = olim;
    else if (q < -olim) q = -olim;
    return q;
  endfunction

  // expected drive word for one tick, advances the shadow state
  function automatic drive_t predict_drive(logic [InDataW-1:0] word, logic armed);
    longint la, ra, lr, rr, tilt;
    drive_t d;
    la = longint'(signed'(word[ValW-1:0]));
    ra = longint'(signed'(word[2*ValW-1:ValW]));
    lr = longint'(signed'(word[3*ValW-1:2*ValW]));
    rr = longint'(signed'(word[4*ValW-1:3*ValW]));
    tilt = longint'(live_gains.tilt_limit);
    d = '0;
    if (armed) begin
      acc_l = wheel_step(acc_l, la, lr, prev_l);
      acc_r = wheel_step(acc_r, ra, rr, prev_r);
      prev_l = lr;
      prev_r = rr;
      if (magnitude(la) < tilt && magnitude(ra) < tilt) begin
        dir_l = (acc_l > 0);
        dir_r = !(acc_r > 0);
        d.left_duty = DutyW'(magnitude(acc_l));
        d.right_duty = DutyW'(magnitude(acc_r));
      end
    end else begin
      acc_l = 0;
      acc_r = 0;
    end
    d.left_dir = dir_l;
    d.right_dir = dir_r;
    return d;
  endfunction

  function automatic plan_row_t tick_row(int la, int ra, int lr, int rr, logic armed);
    plan_row_t r;
    r = '0;
    r.la = ValW'(la);
    r.ra = ValW'(ra);
    r.lr = ValW'(lr);
    r.rr = ValW'(rr);
    r.armed = armed;
    return r;
  endfunction

  function automatic plan_row_t known_row(int la, int ra, int lr, int rr, logic armed,
                                          int ld, logic lt, int rd, logic rt);
    plan_row_t r;
    r = tick_row(la, ra, lr, rr, armed);
    r.pinned = 1'b1;
    r.want = '{left_duty: DutyW'(ld), left_dir: lt, right_duty: DutyW'(rd), right_dir: rt};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] error: %s", $realtime, msg);
  endtask

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // sample both handshakes, predict accepted ticks, check delivered words
  always @(posedge clk) begin : watch
    drive_t got, want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KP:           live_gains.kp = cfg_data[GainW-1:0];
          REG_KI:           live_gains.ki = cfg_data[GainW-1:0];
          REG_KD:           live_gains.kd = cfg_data[GainW-1:0];
          REG_STEP_LIMIT:   live_gains.step_limit = cfg_data[StepW-1:0];
          REG_OUTPUT_LIMIT: live_gains.output_limit = cfg_data[OlimW-1:0];
          REG_TILT_LIMIT:   live_gains.tilt_limit = cfg_data[TiltW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = predict_drive(s_tdata, s_tuser);
        drive_q.push_back(pin_on ? pin_drive : want);
      end
      if (m_tvalid && m_tready) begin
        got = drive_t'(m_tdata);
        if (drive_q.size() == 0) begin
          flag_error($sformatf("unexpected word %h", m_tdata));
        end else begin
          want = drive_q.pop_front();
          if (got.left_duty != want.left_duty || got.left_dir != want.left_dir ||
              got.right_duty != want.right_duty || got.right_dir != want.right_dir)
            flag_error($sformatf(
              "expected L %0d/%0b R %0d/%0b, got L %0d/%0b R %0d/%0b",
              want.left_duty, want.left_dir, want.right_duty, want.right_dir,
              got.left_duty, got.left_dir, got.right_duty, got.right_dir));
        end
      end
    end
  end

  // offer one tick word, with random idle cycles ahead of it
  task automatic send_tick(logic signed [ValW-1:0] la, logic signed [ValW-1:0] ra,
                           logic signed [ValW-1:0] lr, logic signed [ValW-1:0] rr,
                           logic armed, logic pinned, drive_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    pin_on = pinned;
    pin_drive = want;
    s_tvalid <= 1'b1;
    s_tdata <= {rr, lr, ra, la};
    s_tuser <= armed;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // stop offering and let every pending word come out
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (drive_q.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    plan = '{
      // after reset, disarmed and armed at rest
      known_row(0, 0, 0, 0, 1'b0, 0, 1'b0, 0, 1'b0),
      known_row(0, 0, 0, 0, 1'b1, 0, 1'b0, 0, 1'b1),
      // full positive rate, increment clamps at the step limit
      known_row(0, 0, 32767, 32767, 1'b1, 20, 1'b0, 20, 1'b1),
      // most negative angle counts as tilted, pins hold
      known_row(-32768, 0, 0, 0, 1'b1, 0, 1'b0, 0, 1'b1),
      tick_row(32767, 32767, -32768, -32768, 1'b1),
      tick_row(-100, 799, 300, -300, 1'b1),
      // angles right at the tilt bound
      tick_row(0, 800, 50, 50, 1'b1),
      tick_row(-800, 0, 0, 0, 1'b1),
      tick_row(-799, -799, 0, 0, 1'b1),
      tick_row(-600, -600, -40, -40, 1'b1),
      tick_row(-700, -700, 0, 0, 1'b1),
      // disarm clears accumulators but keeps previous rates
      tick_row(0, 0, 1234, -1234, 1'b0),
      tick_row(0, 0, 1234, -1234, 1'b1),
      // output limit of zero pins the accumulators
      cfg_row(REG_OUTPUT_LIMIT, 16'd0),
      known_row(-500, -500, 100, 100, 1'b1, 0, 1'b0, 0, 1'b1),
      cfg_row(REG_OUTPUT_LIMIT, 16'd2047),
      // step limit of zero forces a zero increment
      cfg_row(REG_STEP_LIMIT, 16'd0),
      known_row(-700, 700, -32768, 32767, 1'b1, 0, 1'b0, 0, 1'b1),
      // everything at its top value
      cfg_row(REG_STEP_LIMIT, 16'd255),
      cfg_row(REG_KP, 16'hffff),
      cfg_row(REG_KI, 16'hffff),
      cfg_row(REG_KD, 16'hffff),
      cfg_row(REG_TILT_LIMIT, 16'd32767),
      tick_row(-20000, -20000, -32768, -32768, 1'b1),
      tick_row(-32767, 0, 32767, 32767, 1'b1),
      tick_row(20000, 20000, 32767, 32767, 1'b1),
      // writes past the register file are dropped
      cfg_row(RegSpare6, 16'hffff),
      cfg_row(RegSpare7, 16'h0000),
      tick_row(-1, 1, -1, 1, 1'b1),
      // tilt limit of zero always stops the motors
      cfg_row(REG_TILT_LIMIT, 16'd0),
      tick_row(0, 0, 5, 5, 1'b1),
      // zero gains hold the accumulators, upper data bits are masked
      cfg_row(REG_KP, 16'd0),
      cfg_row(REG_KI, 16'd0),
      cfg_row(REG_KD, 16'd0),
      cfg_row(REG_TILT_LIMIT, 16'hffff),
      tick_row(100, -100, -32768, 32767, 1'b1),
      cfg_row(REG_STEP_LIMIT, 16'hff07),
      cfg_row(REG_KI, 16'h8000),
      tick_row(-16384, 16384, 0, 0, 1'b1),
      cfg_row(REG_OUTPUT_LIMIT, 16'hf805),
      tick_row(-16384, 16384, 0, 0, 1'b1),
      tick_row(0, 0, 0, 0, 1'b0)
    };

    // reset, released on a falling clock edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed plan, no idling
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].la, plan[i].ra, plan[i].lr, plan[i].rr, plan[i].armed,
                  plan[i].pinned, plan[i].want);
      end
    end

    // random phases, each with its own settings, cycling through four idle and stall patterns
    for (int ph = 0; ph < 8; ph++) begin
      logic [CfgDatW-1:0] setv [6];
      logic signed [ValW-1:0] la, ra, lr, rr;
      logic arm;
      int pick, span, bias;
      case (ph)
        0: setv = '{CfgDatW'(KpReset), CfgDatW'(KiReset), CfgDatW'(KdReset),
                    CfgDatW'(StepReset), CfgDatW'(OlimReset), CfgDatW'(TiltReset)};
        1: setv = '{16'hffff, 16'hffff, 16'hffff, 16'h00ff, 16'h07ff, 16'h7fff};
        2: setv = '{16'($urandom), 16'($urandom), 16'($urandom), 16'd3, 16'd40,
                    16'($urandom_range(3000, 200))};
        3: setv = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom)};
        default: setv = '{16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(255, 1)), 16'($urandom_range(2047, 1)),
                          16'($urandom_range(32767, 1))};
      endcase
      wait_results();
      write_reg(REG_KP, setv[0]);
      write_reg(REG_KI, setv[1]);
      write_reg(REG_KD, setv[2]);
      write_reg(REG_STEP_LIMIT, setv[3]);
      write_reg(REG_OUTPUT_LIMIT, setv[4]);
      write_reg(REG_TILT_LIMIT, setv[5]);

      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct = 36;
        end
      endcase
      // long output hold-off while ticks keep coming, fills the queue
      if (ph == 4) hold_left = 60;

      bias = 1;
      for (int n = 0; n < PhaseTicks; n++) begin
        if (n % 40 == 0) bias = $urandom_range(1) ? 1 : -1;
        // sender waits out every pending word once
        if (ph == 5 && n == PhaseTicks / 2) wait_results();
        pick = $urandom_range(99);
        span = (live_gains.tilt_limit > 1) ? int'(live_gains.tilt_limit) - 1 : 0;
        if (pick < 8) begin
          // disarmed noise
          {la, ra, lr, rr} = {$urandom, $urandom};
          arm = 1'b0;
        end else if (pick < 20) begin
          // any field value, mostly tilted
          {la, ra, lr, rr} = {$urandom, $urandom};
          arm = 1'b1;
        end else begin
          // steady lean inside the tilt bound, accumulators walk to saturation
          la = ValW'(bias * int'($urandom_range(span)));
          ra = ValW'(bias * int'($urandom_range(span)));
          if ($urandom_range(3) == 0) ra = -ra;
          lr = ValW'(int'($urandom_range(4000)) - 2000);
          rr = ValW'(int'($urandom_range(4000)) - 2000);
          arm = 1'b1;
        end
        send_tick(la, ra, lr, rr, arm, 1'b0, '0);
      end
    end

    // drain and report
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (errors == 0 && drive_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/twb_pkg.sv
src/twb_lane.sv
src/twb_merge.sv
src/twb_fifo.sv
src/two_wheel_incremental_balance_pid_top.sv
dv/tb_top.sv
